// ===== hdl/network_time_alarm_timer_top_assert.svh =====
// Assertion macros shared by the network time alarm timer checkers.
`ifndef NETWORK_TIME_ALARM_TIMER_TOP_ASSERT_SVH
`define NETWORK_TIME_ALARM_TIMER_TOP_ASSERT_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define NTAT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Concurrent assertion that also holds during reset.
`define NTAT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== hdl/ntat_pkg.sv =====
// Shared types, widths and action codes of the network time alarm timer.
package ntat_pkg;

    localparam int CNT_W  = 24;
    localparam int NT_W   = 15;
    localparam int ACT_W  = 2;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 24;

    localparam logic [ACT_W-1:0] ACT_TICK      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET_TIME  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET_ALARM = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ENABLE    = 2'd3;

    // One period of network time, in counter ticks.
    localparam logic [CNT_W-1:0] PERIOD = 24'h008000;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [NT_W-1:0]  value;
        logic             enable_flag;
    } item_t;

endpackage

// ===== hdl/ntat_compare.sv =====
// Turns an alarm network time into a compare value strictly ahead of the counter.
module ntat_compare
(
    input  logic [ntat_pkg::CNT_W-1:0] counter,
    input  logic [ntat_pkg::NT_W-1:0]  offset,
    input  logic [ntat_pkg::NT_W-1:0]  target,
    output logic [ntat_pkg::CNT_W-1:0] compare
);

    logic [ntat_pkg::NT_W-1:0]  low;
    logic [ntat_pkg::CNT_W-1:0] cand;
    logic [ntat_pkg::CNT_W-1:0] cand_next_period;

    assign low              = target - offset;
    assign cand             = {counter[ntat_pkg::CNT_W-1:ntat_pkg::NT_W], low};
    assign cand_next_period = cand + ntat_pkg::PERIOD;

    // A candidate at or behind the counter moves into the next period.
    assign compare = (cand <= counter) ? cand_next_period : cand;

endmodule

// ===== hdl/network_time_alarm_timer_top.sv =====
// Top level of the network time alarm timer: input stage, state update and result stage.
//
//  Channel | Direction | tdata (low bit up)                         | tuser
//  s_axis  | in        | value[14:0], enable_flag[15]               | action[1:0]
//  m_axis  | out       | net_time[14:0], alarm_fired[15],           | -
//          |           | alarm_armed[16], zeros[23:17]              |
//
// Every accepted transfer yields exactly one result transfer; it passes the input register
// and then the result register. One transfer is accepted per cycle while the output is not
// stalled, since the state update between the two registers is combinational.
// Reset (rst_n low, asynchronous) clears the valid flags of both stages and all timer state.
// A stalled result holds its data, and the input register still takes one more
// transfer behind it before s_axis_tready drops.
module network_time_alarm_timer_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [ntat_pkg::IN_W-1:0]    s_axis_tdata,  // value[14:0], enable_flag[15]
    input  logic [ntat_pkg::ACT_W-1:0]   s_axis_tuser,  // action[1:0]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ntat_pkg::OUT_W-1:0]   m_axis_tdata   // net_time, fired, armed, zeros
);

    // Input stage.
    logic            in_valid_reg;
    logic            in_valid_next;
    ntat_pkg::item_t in_item_reg;

    // Result stage.
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [ntat_pkg::OUT_W-1:0]  out_data_reg;
    logic [ntat_pkg::OUT_W-1:0]  out_data_next;

    // Timer state.
    logic [ntat_pkg::CNT_W-1:0]  counter_reg;
    logic [ntat_pkg::CNT_W-1:0]  counter_next;
    logic [ntat_pkg::NT_W-1:0]   offset_reg;
    logic [ntat_pkg::NT_W-1:0]   offset_next;
    logic [ntat_pkg::NT_W-1:0]   target_reg;
    logic [ntat_pkg::NT_W-1:0]   target_next;
    logic [ntat_pkg::CNT_W-1:0]  compare_reg;
    logic [ntat_pkg::CNT_W-1:0]  compare_next;
    logic                        enable_reg;
    logic                        enable_next;

    logic                        s_accept;
    logic                        out_load;
    logic                        fired;
    logic [ntat_pkg::CNT_W-1:0]  tick_count;
    logic [ntat_pkg::NT_W-1:0]   set_offset;
    logic [ntat_pkg::NT_W-1:0]   arm_offset;
    logic [ntat_pkg::NT_W-1:0]   arm_target;
    logic [ntat_pkg::CNT_W-1:0]  arm_compare;
    logic [ntat_pkg::NT_W-1:0]   net_time;

    // The held item moves into the result stage whenever that stage is free or drains.
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Offset that a set-time action derives from the present counter.
    assign tick_count = counter_reg + 24'd1;
    assign set_offset = in_item_reg.value - counter_reg[ntat_pkg::NT_W-1:0];

    // Set alarm arms the new target against the old offset; set time re-arms
    // the stored target against the new offset.
    assign arm_target = (in_item_reg.action == ntat_pkg::ACT_SET_ALARM)
                        ? in_item_reg.value : target_reg;
    assign arm_offset = (in_item_reg.action == ntat_pkg::ACT_SET_TIME)
                        ? set_offset : offset_reg;

    ntat_compare u_compare
    (
        .counter (counter_reg),
        .offset  (arm_offset),
        .target  (arm_target),
        .compare (arm_compare)
    );

    always_comb
    begin
        counter_next = counter_reg;
        offset_next  = offset_reg;
        target_next  = target_reg;
        compare_next = compare_reg;
        enable_next  = enable_reg;
        fired        = 1'b0;
        unique case (in_item_reg.action)
            ntat_pkg::ACT_TICK:
            begin
                counter_next = tick_count;
                if (enable_reg && (tick_count == compare_reg))
                begin
                    fired       = 1'b1;
                    enable_next = 1'b0;
                end
            end
            ntat_pkg::ACT_SET_TIME:
            begin
                offset_next = set_offset;
                if (enable_reg)
                begin
                    compare_next = arm_compare;
                end
            end
            ntat_pkg::ACT_SET_ALARM:
            begin
                target_next  = in_item_reg.value;
                compare_next = arm_compare;
                enable_next  = 1'b1;
            end
            ntat_pkg::ACT_ENABLE:
            begin
                enable_next = in_item_reg.enable_flag;
            end
            default:
            begin
                enable_next = enable_reg;
            end
        endcase
    end

    assign net_time      = counter_next[ntat_pkg::NT_W-1:0] + offset_next;
    assign out_data_next = {7'd0, enable_next, fired, net_time};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            counter_reg   <= '0;
            offset_reg    <= '0;
            target_reg    <= '0;
            compare_reg   <= '0;
            enable_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                counter_reg <= counter_next;
                offset_reg  <= offset_next;
                target_reg  <= target_next;
                compare_reg <= compare_next;
                enable_reg  <= enable_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.action      <= s_axis_tuser;
            in_item_reg.value       <= s_axis_tdata[ntat_pkg::NT_W-1:0];
            in_item_reg.enable_flag <= s_axis_tdata[ntat_pkg::NT_W];
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== hdl/ntat_checker.sv =====
// Port-level checker of the network time alarm timer and its bind.
`include "network_time_alarm_timer_top_assert.svh"

module ntat_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [ntat_pkg::IN_W-1:0]   s_axis_tdata,
    input logic [ntat_pkg::ACT_W-1:0]  s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [ntat_pkg::OUT_W-1:0]  m_axis_tdata
);

    logic unused_inputs;
    assign unused_inputs = s_axis_tvalid ^ (^s_axis_tdata) ^ (^s_axis_tuser);

    // A stalled result keeps its valid and its data.
    `NTAT_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // A firing alarm always clears the enable in the same result.
    `NTAT_ASSERT(a_fire_disarms, clk, rst_n, m_axis_tvalid && m_axis_tdata[15] |-> !m_axis_tdata[16] && !unused_inputs || m_axis_tvalid && m_axis_tdata[15] && !m_axis_tdata[16])

    // With the result stage empty the block can always take a transfer.
    `NTAT_ASSERT_ALWAYS(a_ready_when_empty, clk, !m_axis_tvalid |-> s_axis_tready)

endmodule

bind network_time_alarm_timer_top ntat_checker u_ntat_checker (.*);

// ===== tb/sv/network_time_alarm_timer_top_test.sv =====
// Self-checking stream testbench for the network time alarm timer top level.
module network_time_alarm_timer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // A stalled input stage may be held for the pressure test's hold-off plus short random
    // stalls. This limit on cycles without any transfer sits well above that.
    localparam int STALL_LIMIT   = 2000;
    // The result passes only the input and result registers, so a short wait covers stragglers.
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_OFF_LEN  = 64;

    // One predicted result transfer, in the field order of m_axis_tdata.
    typedef struct packed {
        logic [ntat_pkg::NT_W-1:0] net_time;
        logic                      alarm_fired;
        logic                      alarm_armed;
    } timer_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ntat_pkg::IN_W-1:0]     s_axis_tdata = '0;   // value[14:0], enable_flag[15]
    logic [ntat_pkg::ACT_W-1:0]    s_axis_tuser = '0;   // action[1:0]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ntat_pkg::OUT_W-1:0]    m_axis_tdata;   // net_time[14:0], fired[15], armed[16]

    // Predicted timer state, updated once per accepted input transfer.
    logic [ntat_pkg::CNT_W-1:0]    sleep_count   = '0;
    logic [ntat_pkg::NT_W-1:0]     nt_offset     = '0;
    logic [ntat_pkg::NT_W-1:0]     alarm_time    = '0;
    logic [ntat_pkg::CNT_W-1:0]    alarm_compare = '0;
    logic                          alarm_enabled = 1'b0;

    timer_result_t       expected_results[$];
    int unsigned         fail_count = 0;
    int unsigned         quiet_cycles = 0;

    // Idle percentages for each side; the receiver also honors a one-shot long hold-off.
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int unsigned         hold_off_len = 0;

    network_time_alarm_timer_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor of the timer.
    // ------------------------------------------------------------------

    function automatic logic [ntat_pkg::NT_W-1:0] net_time_now();
        return sleep_count[ntat_pkg::NT_W-1:0] + nt_offset;
    endfunction

    // Places the alarm strictly ahead of the counter: in the current 32768-tick period if
    // its low bits still lie ahead, otherwise one period later, wrapping at the counter width.
    function automatic logic [ntat_pkg::CNT_W-1:0] alarm_to_compare(
        logic [ntat_pkg::NT_W-1:0] target);
        logic [ntat_pkg::NT_W-1:0]  low_bits;
        logic [ntat_pkg::CNT_W-1:0] candidate;
        low_bits  = target - nt_offset;
        candidate = {sleep_count[ntat_pkg::CNT_W-1:ntat_pkg::NT_W], low_bits};
        if (candidate <= sleep_count)
            candidate = candidate + ntat_pkg::PERIOD;
        return candidate;
    endfunction

    function automatic void arm_alarm(logic [ntat_pkg::NT_W-1:0] target);
        alarm_time    = target;
        alarm_compare = alarm_to_compare(target);
        alarm_enabled = 1'b1;
    endfunction

    // Applies one accepted transfer to the predicted state and queues the result it causes.
    function automatic void advance_timer(logic [ntat_pkg::ACT_W-1:0] act,
                                          logic [ntat_pkg::NT_W-1:0] val, logic flag);
        timer_result_t res;
        res.alarm_fired = 1'b0;
        case (act)
            ntat_pkg::ACT_TICK:
            begin
                sleep_count = sleep_count + 1'b1;
                if (alarm_enabled && sleep_count == alarm_compare)
                begin
                    res.alarm_fired = 1'b1;
                    alarm_enabled   = 1'b0;
                end
            end
            ntat_pkg::ACT_SET_TIME:
            begin
                nt_offset = val - sleep_count[ntat_pkg::NT_W-1:0];
                if (alarm_enabled)
                    arm_alarm(alarm_time);
            end
            ntat_pkg::ACT_SET_ALARM:
                arm_alarm(val);
            default:
                alarm_enabled = flag;
        endcase
        res.net_time    = net_time_now();
        res.alarm_armed = alarm_enabled;
        expected_results.push_back(res);
    endfunction

    function automatic void check_result(logic [ntat_pkg::OUT_W-1:0] word);
        timer_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result transfer 0x%06h arrived with no expectation waiting", word);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (word[ntat_pkg::NT_W-1:0] !== want.net_time)
        begin
            $error("net_time mismatch: expected %0d, actual %0d", want.net_time,
                   word[ntat_pkg::NT_W-1:0]);
            fail_count++;
        end
        if (word[ntat_pkg::NT_W] !== want.alarm_fired)
        begin
            $error("alarm_fired mismatch: expected %0b, actual %0b", want.alarm_fired,
                   word[ntat_pkg::NT_W]);
            fail_count++;
        end
        if (word[ntat_pkg::NT_W+1] !== want.alarm_armed)
        begin
            $error("alarm_armed mismatch: expected %0b, actual %0b", want.alarm_armed,
                   word[ntat_pkg::NT_W+1]);
            fail_count++;
        end
        if (word[ntat_pkg::OUT_W-1:ntat_pkg::NT_W+2] !== '0)
        begin
            $error("padding mismatch: expected 0, actual 0x%0h",
                   word[ntat_pkg::OUT_W-1:ntat_pkg::NT_W+2]);
            fail_count++;
        end
    endfunction

    // Both handshakes are observed in one place at each rising edge. Inputs are predicted
    // before outputs are checked, although a result can never share an edge with its own
    // input transfer because of the two-stage pipeline.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_timer(s_axis_tuser, s_axis_tdata[ntat_pkg::NT_W-1:0],
                              s_axis_tdata[ntat_pkg::NT_W]);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
        end
    end

    // Watchdog: any stretch without a transfer on either side that reaches the limit
    // means the block has hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result receiver. A hold-off request keeps tready low for the requested number of
    // cycles, counted here, while the sender keeps offering transfers.
    initial
    begin
        int unsigned stall_left;
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                stall_left   = hold_off_len;
                hold_off_len = 0;
                m_axis_tready <= 1'b0;
                repeat (stall_left) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Offers one transfer, after a random gap, and returns at the edge that accepts it.
    task automatic send_item(input logic [ntat_pkg::ACT_W-1:0] act,
                             input logic [ntat_pkg::NT_W-1:0] val, input logic flag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {flag, val};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stops offering and waits until every predicted result has been seen, so that the
    // predicted state is exact when the next test chooses its values.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Out of reset the counter starts at zero and the alarm is off. Unused fields are
    // driven to all ones to show they are ignored.
    task automatic test_after_reset();
        send_item(ntat_pkg::ACT_TICK, '1, 1'b1);
        send_item(ntat_pkg::ACT_ENABLE, '1, 1'b0);
        send_item(ntat_pkg::ACT_TICK, '0, 1'b0);
    endtask

    // Network time at both extremes, including the wrap from the top value to zero.
    task automatic test_set_time();
        send_item(ntat_pkg::ACT_SET_TIME, 15'h7FFF, 1'b1);
        send_item(ntat_pkg::ACT_TICK, '0, 1'b0);
        send_item(ntat_pkg::ACT_SET_TIME, 15'h0000, 1'b0);
        send_item(ntat_pkg::ACT_SET_TIME, 15'h5555, 1'b1);
    endtask

    // The enable action only sets the flag; the compare value left by reset lies far away,
    // so nothing fires while the counter runs.
    task automatic test_interrupt_enable();
        send_item(ntat_pkg::ACT_ENABLE, '0, 1'b1);
        send_item(ntat_pkg::ACT_TICK, '0, 1'b0);
        send_item(ntat_pkg::ACT_ENABLE, '1, 1'b0);
        send_item(ntat_pkg::ACT_ENABLE, '0, 1'b0);
    endtask

    // An alarm a few ticks ahead fires exactly once and then disarms itself. Alarms at
    // the extremes of the value field are armed and then dropped again.
    task automatic test_alarm_fire();
        wait_for_results();
        send_item(ntat_pkg::ACT_SET_ALARM, net_time_now() + 15'd3, 1'b0);
        repeat (4) send_item(ntat_pkg::ACT_TICK, '0, 1'b0);
        send_item(ntat_pkg::ACT_SET_ALARM, 15'h7FFF, 1'b1);
        send_item(ntat_pkg::ACT_SET_ALARM, 15'h0000, 1'b0);
        send_item(ntat_pkg::ACT_ENABLE, '0, 1'b0);
    endtask

    // Setting the time while armed moves the compare value with the new offset; setting
    // it while disarmed leaves the alarm off.
    task automatic test_rearm_on_set_time();
        wait_for_results();
        send_item(ntat_pkg::ACT_SET_ALARM, net_time_now() + 15'd4, 1'b0);
        send_item(ntat_pkg::ACT_SET_TIME, net_time_now() + 15'd2, 1'b0);
        wait_for_results();
        send_item(ntat_pkg::ACT_TICK, '0, 1'b0);
        send_item(ntat_pkg::ACT_TICK, '0, 1'b0);
        send_item(ntat_pkg::ACT_SET_TIME, 15'h2AAA, 1'b1);
    endtask

    // An alarm equal to the present network time belongs to the next period: it stays
    // armed and silent through a run of ticks until the enable is dropped.
    task automatic test_alarm_next_period();
        wait_for_results();
        send_item(ntat_pkg::ACT_SET_ALARM, net_time_now(), 1'b1);
        repeat (16) send_item(ntat_pkg::ACT_TICK, 15'($urandom), 1'($urandom));
        send_item(ntat_pkg::ACT_ENABLE, 15'($urandom), 1'b0);
    endtask

    // The receiver holds off for a long stretch while transfers keep coming, so the
    // pipeline fills and s_axis_tready has to drop.
    task automatic test_backpressure();
        wait_for_results();
        hold_off_len = HOLD_OFF_LEN;
        repeat (24) send_item(2'($urandom), 15'($urandom), 1'($urandom));
    endtask

    // Mostly alarm episodes: an alarm a short way ahead (sometimes exactly now) followed by
    // a run of ticks with the odd time or enable change mixed in. The rest is noise.
    task automatic test_random(input int unsigned item_count);
        int unsigned sent = 0;
        int unsigned run_len;
        logic [ntat_pkg::NT_W-1:0] lead;
        while (sent < item_count)
        begin
            if ($urandom_range(99) < 55)
            begin
                lead = ($urandom_range(9) == 0) ? '0 : 15'($urandom_range(1, 24));
                send_item(ntat_pkg::ACT_SET_ALARM, net_time_now() + lead, 1'($urandom));
                run_len = $urandom_range(1, 30);
                repeat (run_len)
                begin
                    case ($urandom_range(19))
                        0:       send_item(ntat_pkg::ACT_SET_TIME, 15'($urandom),
                                           1'($urandom));
                        1:       send_item(ntat_pkg::ACT_SET_TIME, net_time_now(),
                                           1'($urandom));
                        2:       send_item(ntat_pkg::ACT_ENABLE, 15'($urandom),
                                           1'($urandom));
                        default: send_item(ntat_pkg::ACT_TICK, 15'($urandom),
                                           1'($urandom));
                    endcase
                end
                sent += run_len + 1;
            end
            else
            begin
                send_item(2'($urandom), 15'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence. The three idling phases are: slow sender with a slower receiver,
    // the reverse, and both sides at full rate.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 51;
        test_after_reset();
        test_set_time();
        test_interrupt_enable();
        test_alarm_fire();
        test_rearm_on_set_time();
        test_random(180);

        send_idle_pct = 51;
        recv_idle_pct = 36;
        test_backpressure();
        test_random(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_alarm_next_period();
        test_random(190);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
